FILE: hdl/lra_pkg.sv
// ---------------------------------------------------------------------------
// lra_pkg
// Shared constants, codes and types of the label region adjacency unit.
// ---------------------------------------------------------------------------
package lra_pkg;

   // label and seen-pair matrix geometry
   localparam int LABEL_W    = 6;
   localparam int MAX_LABELS = 64;
   localparam int ROW_W      = $clog2(MAX_LABELS);

   // line geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 11;

   // register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EIGHT_CONNECTED = 1'd1;

   localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = WIDTH_W'(MAX_WIDTH);

   // neighbor slots, in result order
   localparam int NB_COUNT = 4;
   localparam int NB_SEL_W = 2;
   localparam logic [NB_SEL_W-1:0] NB_LEFT    = 2'd0;
   localparam logic [NB_SEL_W-1:0] NB_UP      = 2'd1;
   localparam logic [NB_SEL_W-1:0] NB_UPLEFT  = 2'd2;
   localparam logic [NB_SEL_W-1:0] NB_UPRIGHT = 2'd3;

   typedef logic [LABEL_W-1:0]    label_type;
   typedef logic [MAX_LABELS-1:0] seen_row_type;

   // line buffer access of one accepted pixel
   typedef struct packed {
      logic                 en;
      logic [COL_W-1:0]     col;
      logic [COL_W-1:0]     col_next;
      label_type            label;
   } lb_access_type;

   // seen-pair matrix write port
   typedef struct packed {
      logic                 en;
      logic [ROW_W-1:0]     row;
      seen_row_type         bits;
   } seen_wr_type;

endpackage

FILE: hdl/label_region_adjacency_unit.sv
// ---------------------------------------------------------------------------
// label_region_adjacency_unit
// Region adjacency pairs from a raster-order label image stream.
// ---------------------------------------------------------------------------
// Usage:
//  req_*  one pixel label per beat, raster order; req_start_of_frame marks the
//         first pixel of a frame and clears the seen-pair matrix.
//  rsp_*  one new adjacent label pair per beat, smaller label first;
//         rsp_last_in_run marks the last pair caused by one pixel. Pairs come
//         in neighbor order left, up, up-left, up-right.
//  csr_*  register writes (image_width, eight_connected), only while idle.
// Path: a pixel's pairs pass the pixel stage, pair check, pending slot and rsp;
//  the last pair of a pixel waits until all its neighbors are checked.
// Throughput: one pixel per cycle while a pixel has at most one candidate
//  neighbor pair and rsp does not stall; a pixel with k candidates (k up to
//  4) holds the pixel stage until it has issued all k, because the seen-pair
//  memory has one read port. A frame start waits until the pixel stage and
//  the pair check are empty, which a stalled rsp can delay.
// Reset: registers return to width 1024 and four-connectivity; the seen
//  matrix reads empty at once (row valid flags), no clearing pass is needed.
// Stall: a stalled rsp holds the pair check pipeline once a pair is pending;
//  pixels without candidates keep flowing until the pixel stage fills.
// ---------------------------------------------------------------------------
module label_region_adjacency_unit (
   input  logic                           clock,
   input  logic                           reset,
   // pixel channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lra_pkg::LABEL_W-1:0]    req_pixel_label,
   input  logic                           req_start_of_frame,
   // pair channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lra_pkg::LABEL_W-1:0]    rsp_zone_low,
   output logic [lra_pkg::LABEL_W-1:0]    rsp_zone_high,
   output logic                           rsp_last_in_run,
   // register port
   input  logic                           csr_write_enable,
   input  logic [lra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lra_pkg::CSR_DATA_W-1:0] csr_write_data
);

   // ---------------- registers ----------------
   logic [lra_pkg::WIDTH_W-1:0] cfg_width_ff, cfg_width_in;
   logic                        cfg_eight_ff, cfg_eight_in;

   always_comb begin
      cfg_width_in = cfg_width_ff;
      cfg_eight_in = cfg_eight_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lra_pkg::REG_IMAGE_WIDTH:     cfg_width_in = csr_write_data;
            lra_pkg::REG_EIGHT_CONNECTED: cfg_eight_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // width 0 acts as 1, anything above the line store saturates
   logic [lra_pkg::WIDTH_W-1:0] eff_width;
   always_comb begin
      if (cfg_width_ff == '0) begin
         eff_width = lra_pkg::WIDTH_W'(1);
      end else if (cfg_width_ff > lra_pkg::WIDTH_W'(lra_pkg::MAX_WIDTH)) begin
         eff_width = lra_pkg::WIDTH_W'(lra_pkg::MAX_WIDTH);
      end else begin
         eff_width = cfg_width_ff;
      end
   end

   // ---------------- pixel accept / column tracking ----------------
   logic                        req_fire;
   logic [lra_pkg::COL_W-1:0]   col_ff, col_in;
   logic                        first_row_ff, first_row_in;
   logic [lra_pkg::COL_W-1:0]   col_base, x;
   logic                        fr_base, fr;
   logic [lra_pkg::WIDTH_W-1:0] x_next;
   logic                        row_end;

   always_comb begin
      col_base = req_start_of_frame ? '0 : col_ff;
      fr_base  = req_start_of_frame ? 1'b1 : first_row_ff;
      // width shrunk under the current column: new row
      if ({1'b0, col_base} >= eff_width) begin
         x  = '0;
         fr = 1'b0;
      end else begin
         x  = col_base;
         fr = fr_base;
      end
      x_next  = {1'b0, x} + lra_pkg::WIDTH_W'(1);
      row_end = x_next >= eff_width;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (req_fire) begin
         col_in       = row_end ? '0 : x_next[lra_pkg::COL_W-1:0];
         first_row_in = row_end ? 1'b0 : fr;
      end
   end

   lra_pkg::lb_access_type lb_access;
   lra_pkg::label_type     lb_up, lb_upright;

   assign lb_access.en       = req_fire;
   assign lb_access.col      = x;
   assign lb_access.col_next = x_next[lra_pkg::COL_W-1:0];
   assign lb_access.label    = req_pixel_label;

   lra_line_buffer u_line_buffer (
      .clock      (clock),
      .access     (lb_access),
      .rd_up      (lb_up),
      .rd_upright (lb_upright)
   );

   // ---------------- pixel stage ----------------
   // Holds one pixel with its neighbors; hands out one candidate pair per
   // cycle to the pair check while the pair check is not stalled.
   logic                       s1_valid_ff, s1_valid_in;
   lra_pkg::label_type         s1_label_ff, s1_label_in;
   logic                       s1_x_gt0_ff, s1_x_gt0_in;
   logic                       s1_has_up_ff, s1_has_up_in;
   logic                       s1_ur_ok_ff, s1_ur_ok_in;
   logic                       s1_eight_ff, s1_eight_in;
   logic [lra_pkg::NB_COUNT-1:0] s1_taken_ff, s1_taken_in;
   lra_pkg::label_type         left_ff, left_in;
   lra_pkg::label_type         upleft_ff, upleft_in;

   lra_pkg::label_type           nb [lra_pkg::NB_COUNT];
   logic [lra_pkg::NB_COUNT-1:0] nb_en, cand, remaining;
   logic [lra_pkg::NB_SEL_W-1:0] sel;
   logic                         single;
   lra_pkg::label_type           sel_label, cand_lo, cand_hi;
   logic                         stall, issue, s1_leave;

   always_comb begin
      nb[lra_pkg::NB_LEFT]    = left_ff;
      nb[lra_pkg::NB_UP]      = lb_up;
      nb[lra_pkg::NB_UPLEFT]  = upleft_ff;
      nb[lra_pkg::NB_UPRIGHT] = lb_upright;
      nb_en[lra_pkg::NB_LEFT]    = s1_x_gt0_ff;
      nb_en[lra_pkg::NB_UP]      = s1_has_up_ff;
      nb_en[lra_pkg::NB_UPLEFT]  = s1_eight_ff && s1_has_up_ff && s1_x_gt0_ff;
      nb_en[lra_pkg::NB_UPRIGHT] = s1_eight_ff && s1_has_up_ff && s1_ur_ok_ff;
      // foreground, different label, and not a repeat within this pixel
      for (int i = 0; i < lra_pkg::NB_COUNT; i++) begin
         cand[i] = nb_en[i] && (nb[i] != '0) && (s1_label_ff != '0)
                   && (nb[i] != s1_label_ff);
         for (int j = 0; j < i; j++) begin
            if (nb_en[j] && (nb[j] == nb[i])) begin
               cand[i] = 1'b0;
            end
         end
      end
      remaining = cand & ~s1_taken_ff;
      sel = '0;
      for (int i = lra_pkg::NB_COUNT - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            sel = lra_pkg::NB_SEL_W'(i);
         end
      end
      single    = (remaining & (remaining - lra_pkg::NB_COUNT'(1))) == '0;
      sel_label = nb[sel];
      if (s1_label_ff < sel_label) begin
         cand_lo = s1_label_ff;
         cand_hi = sel_label;
      end else begin
         cand_lo = sel_label;
         cand_hi = s1_label_ff;
      end
   end

   assign issue    = s1_valid_ff && (remaining != '0) && !stall;
   assign s1_leave = s1_valid_ff && ((remaining == '0) || (!stall && single));

   // ---------------- pair check stage ----------------
   logic               r_valid_ff, r_valid_in;
   lra_pkg::label_type r_lo_ff, r_lo_in;
   lra_pkg::label_type r_hi_ff, r_hi_in;
   logic               r_final_ff, r_final_in;

   // frame start only once nothing is left to check
   assign req_ready = (!s1_valid_ff || s1_leave)
                      && (!req_start_of_frame || (!s1_valid_ff && !r_valid_ff));
   assign req_fire  = req_valid && req_ready;

   lra_pkg::seen_row_type seen_bits;
   lra_pkg::seen_wr_type  seen_wr;
   logic                  is_new, act;

   assign act    = r_valid_ff && !stall;
   assign is_new = !seen_bits[r_hi_ff];

   assign seen_wr.en   = act && is_new;
   assign seen_wr.row  = r_lo_ff;
   assign seen_wr.bits = seen_bits | (lra_pkg::MAX_LABELS'(1) << r_hi_ff);

   lra_seen_table u_seen_table (
      .clock   (clock),
      .reset   (reset),
      .clear   (req_fire && req_start_of_frame),
      .rd_en   (issue),
      .rd_row  (cand_lo),
      .wr      (seen_wr),
      .rd_bits (seen_bits)
   );

   // ---------------- pending pair / result register ----------------
   // A new pair waits in the pending slot until the next candidate of its
   // pixel is checked: only then is it known whether it closes the run.
   // A done pending pair closes its run and goes out with last set.
   logic               pend_valid_ff, pend_valid_in;
   lra_pkg::label_type pend_lo_ff, pend_lo_in;
   lra_pkg::label_type pend_hi_ff, pend_hi_in;
   logic               pend_done_ff, pend_done_in;
   logic               out_free, emit, emit_last;

   logic               rsp_valid_ff, rsp_valid_in;
   lra_pkg::label_type rsp_low_ff, rsp_low_in;
   lra_pkg::label_type rsp_high_ff, rsp_high_in;
   logic               rsp_last_ff, rsp_last_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stall     = pend_valid_ff && !out_free;
   assign emit      = !stall && pend_valid_ff
                      && (pend_done_ff || (r_valid_ff && (is_new || r_final_ff)));
   assign emit_last = pend_done_ff || (r_valid_ff && !is_new && r_final_ff);

   always_comb begin
      // pixel stage
      s1_valid_in  = s1_valid_ff;
      s1_label_in  = s1_label_ff;
      s1_x_gt0_in  = s1_x_gt0_ff;
      s1_has_up_in = s1_has_up_ff;
      s1_ur_ok_in  = s1_ur_ok_ff;
      s1_eight_in  = s1_eight_ff;
      s1_taken_in  = s1_taken_ff;
      left_in      = left_ff;
      upleft_in    = upleft_ff;
      if (s1_leave) begin
         s1_valid_in = 1'b0;
         left_in     = s1_label_ff;
         upleft_in   = lb_up;
      end else if (issue) begin
         s1_taken_in = s1_taken_ff | (lra_pkg::NB_COUNT'(1) << sel);
      end
      if (req_fire) begin
         s1_valid_in  = 1'b1;
         s1_label_in  = req_pixel_label;
         s1_x_gt0_in  = x != '0;
         s1_has_up_in = !fr;
         s1_ur_ok_in  = !row_end;
         s1_eight_in  = cfg_eight_ff;
         s1_taken_in  = '0;
      end

      // pair check stage
      r_valid_in = r_valid_ff;
      r_lo_in    = r_lo_ff;
      r_hi_in    = r_hi_ff;
      r_final_in = r_final_ff;
      if (!stall) begin
         r_valid_in = issue;
         r_lo_in    = cand_lo;
         r_hi_in    = cand_hi;
         r_final_in = single;
      end

      // pending slot
      pend_valid_in = pend_valid_ff;
      pend_lo_in    = pend_lo_ff;
      pend_hi_in    = pend_hi_ff;
      pend_done_in  = pend_done_ff;
      if (act && is_new) begin
         pend_valid_in = 1'b1;
         pend_lo_in    = r_lo_ff;
         pend_hi_in    = r_hi_ff;
         pend_done_in  = r_final_ff;
      end else if (emit) begin
         pend_valid_in = 1'b0;
      end

      // result register
      rsp_valid_in = rsp_valid_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_low_in   = pend_lo_ff;
         rsp_high_in  = pend_hi_ff;
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_label_ff  <= s1_label_in;
      s1_x_gt0_ff  <= s1_x_gt0_in;
      s1_has_up_ff <= s1_has_up_in;
      s1_ur_ok_ff  <= s1_ur_ok_in;
      s1_eight_ff  <= s1_eight_in;
      left_ff      <= left_in;
      upleft_ff    <= upleft_in;
      r_lo_ff      <= r_lo_in;
      r_hi_ff      <= r_hi_in;
      r_final_ff   <= r_final_in;
      pend_lo_ff   <= pend_lo_in;
      pend_hi_ff   <= pend_hi_in;
      pend_done_ff <= pend_done_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= lra_pkg::IMAGE_WIDTH_RESET;
         cfg_eight_ff  <= 1'b0;
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         s1_valid_ff   <= 1'b0;
         s1_taken_ff   <= '0;
         r_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_width_ff  <= cfg_width_in;
         cfg_eight_ff  <= cfg_eight_in;
         col_ff        <= col_in;
         first_row_ff  <= first_row_in;
         s1_valid_ff   <= s1_valid_in;
         s1_taken_ff   <= s1_taken_in;
         r_valid_ff    <= r_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_zone_low    = rsp_low_ff;
   assign rsp_zone_high   = rsp_high_ff;
   assign rsp_last_in_run = rsp_last_ff;

   // ---------------- checks ----------------
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("pair emitted into an occupied result register");

   a_open_run_has_work: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !pend_done_ff |-> r_valid_ff || s1_valid_ff)
      else $error("pending pair left without a closing candidate");

   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_low_ff != '0) && (rsp_low_ff < rsp_high_ff))
      else $error("result pair not ordered or holds background");

   a_frame_start_drained: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_start_of_frame |-> !r_valid_ff && !s1_valid_ff)
      else $error("frame start taken with pairs still in check");

endmodule

FILE: hdl/lra_line_buffer.sv
// ---------------------------------------------------------------------------
// lra_line_buffer
// One-row label store: read-first, two read ports (up, up-right), one write.
// ---------------------------------------------------------------------------
module lra_line_buffer (
   input  logic                  clock,
   input  lra_pkg::lb_access_type access,
   output lra_pkg::label_type    rd_up,
   output lra_pkg::label_type    rd_upright
);

   lra_pkg::label_type row_mem_ff [lra_pkg::MAX_WIDTH];
   lra_pkg::label_type up_ff;
   lra_pkg::label_type upright_ff;

   // read data holds between accesses, so the pixel stage can stall on it
   always_ff @(posedge clock) begin
      if (access.en) begin
         up_ff      <= row_mem_ff[access.col];
         upright_ff <= row_mem_ff[access.col_next];
         row_mem_ff[access.col] <= access.label;
      end
   end

   assign rd_up      = up_ff;
   assign rd_upright = upright_ff;

endmodule

FILE: hdl/lra_seen_table.sv
// ---------------------------------------------------------------------------
// lra_seen_table
// Seen-pair bit matrix: one row per smaller label, one bit per larger label.
// Row valid flags clear it at a frame start with no clearing pass; the last write is forwarded.
// ---------------------------------------------------------------------------
module lra_seen_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      rd_en,
   input  logic [lra_pkg::ROW_W-1:0] rd_row,
   input  lra_pkg::seen_wr_type      wr,
   output lra_pkg::seen_row_type     rd_bits
);

   lra_pkg::seen_row_type      seen_mem_ff [lra_pkg::MAX_LABELS];
   lra_pkg::seen_row_type      rd_q_ff;
   logic [lra_pkg::ROW_W-1:0]  rd_row_ff;
   logic [lra_pkg::MAX_LABELS-1:0] row_valid_ff, row_valid_in;
   logic                       fwd_valid_ff, fwd_valid_in;
   logic [lra_pkg::ROW_W-1:0]  fwd_row_ff;
   lra_pkg::seen_row_type      fwd_bits_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff   <= seen_mem_ff[rd_row];
         rd_row_ff <= rd_row;
      end
      if (wr.en) begin
         seen_mem_ff[wr.row] <= wr.bits;
         fwd_row_ff          <= wr.row;
         fwd_bits_ff         <= wr.bits;
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (clear) begin
         row_valid_in = '0;
         fwd_valid_in = 1'b0;
      end else if (wr.en) begin
         row_valid_in[wr.row] = 1'b1;
         fwd_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   // the latest write is the current content of its row
   always_comb begin
      if (fwd_valid_ff && (fwd_row_ff == rd_row_ff)) begin
         rd_bits = fwd_bits_ff;
      end else if (row_valid_ff[rd_row_ff]) begin
         rd_bits = rd_q_ff;
      end else begin
         rd_bits = '0;
      end
   end

   a_write_marks_row: assert property (@(posedge clock) disable iff (reset)
      wr.en && !clear |=> row_valid_ff[$past(wr.row)])
      else $error("seen row not marked valid after write");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear |=> (row_valid_ff == '0) && !fwd_valid_ff)
      else $error("seen matrix not empty after frame clear");

   a_no_write_on_clear: assert property (@(posedge clock) disable iff (reset)
      clear |-> !wr.en)
      else $error("seen write collides with frame clear");

endmodule
